// ===== rtl/core/rsc_pkg.sv =====
`default_nettype none

package rsc_pkg;

   localparam int WINDOW_BYTES = 12;
   localparam int HEADER_BYTES = 8;
   localparam int FILL_BITS    = 4;
   localparam int LENGTH_BITS  = 33;
   localparam int TOTAL_BITS   = 32;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [31:0] TAG_RIFF  = 32'h5249_4646;
   localparam logic [31:0] TAG_RIFX  = 32'h5249_4658;
   localparam logic [31:0] FORM_WAVE = 32'h5741_5645;
   localparam logic [31:0] FORM_XWMA = 32'h5857_4D41;

   localparam logic [LENGTH_BITS-1:0] MIN_LENGTH_RESET = LENGTH_BITS'(1024);
   localparam logic [LENGTH_BITS-1:0] MAX_LENGTH_RESET = LENGTH_BITS'(1024 * 1024 * 100);

   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_LENGTH   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_LENGTH   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOTAL_LENGTH = 2'd2;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic        tag_ok;
      logic        big_endian;
      logic        form_xwma;
      logic [31:0] size;
   } hdr_type;

endpackage

`default_nettype wire

// ===== rtl/core/rsc_cell.sv =====
`default_nettype none

module rsc_cell (
   input  wire                 clock,
   input  wire                 shift_en,
   input  rsc_pkg::byte_type   byte_in,
   output rsc_pkg::byte_type   byte_out
);
   import rsc_pkg::*;

   byte_type byte_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rsc_window.sv =====
`default_nettype none

module rsc_window (
   input  wire                 clock,
   input  wire                 shift_en,
   input  rsc_pkg::byte_type   data_byte,
   output rsc_pkg::hdr_type    hdr
);
   import rsc_pkg::*;

   // cells hold the newest bytes right-aligned; nxt is the window after this shift
   byte_type cell_q [WINDOW_BYTES];
   byte_type nxt    [WINDOW_BYTES];

   logic [31:0] tag_word;
   logic [31:0] form_word;
   logic        riff;
   logic        rifx;
   logic        wave;
   logic        xwma;

   for (genvar i = 0; i < WINDOW_BYTES; i++) begin : g_cell
      if (i == WINDOW_BYTES - 1) begin : g_last
         assign nxt[i] = data_byte;
      end else begin : g_mid
         assign nxt[i] = cell_q[i+1];
      end
      rsc_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .byte_in  (nxt[i]),
         .byte_out (cell_q[i])
      );
   end

   always_comb begin
      tag_word  = {nxt[0], nxt[1], nxt[2], nxt[3]};
      form_word = {nxt[8], nxt[9], nxt[10], nxt[11]};
      riff      = (tag_word == TAG_RIFF);
      rifx      = (tag_word == TAG_RIFX);
      wave      = (form_word == FORM_WAVE);
      xwma      = (form_word == FORM_XWMA);
      hdr.tag_ok     = (riff || rifx) && (wave || xwma);
      hdr.big_endian = rifx;
      hdr.form_xwma  = xwma;
      hdr.size       = rifx ? {nxt[4], nxt[5], nxt[6], nxt[7]}
                            : {nxt[7], nxt[6], nxt[5], nxt[4]};
   end

endmodule

`default_nettype wire

// ===== rtl/core/riff_stream_carver.sv =====
`default_nettype none

// RIFF/RIFX container carver.
// req_*: one buffer byte per transaction, in order from offset zero.
// rsp_*: one transaction per accepted container: running index, tag offset,
//   length (size field plus eight), RIFX flag and XWMA flag.
// csr_*: write-only registers 0 min_length, 1 max_length, 2 total_length; the user
//   must write them only while the block is idle, as the block itself does not enforce it.
// Throughput: one byte per cycle while req_ready is high. The header window is a row of
//   twelve byte cells shifted once per byte outside a skipped container; the tag,
//   size and bound checks run on the shifted window in the same cycle as the byte.
// Latency: a result is presented on rsp_valid the cycle after the byte that
//   completes its twelve-byte header.
// Stall: the result sits in an output register; req_ready stays high while
//   that register is empty or being taken, and drops only while a result
//   is held with rsp_ready low.
// Reset: empty window, position, skip and index counters at zero, registers
//   at their defaults; bytes are accepted in the first cycle after reset.
module riff_stream_carver #(
   parameter int POSITION_BITS = 32,
   parameter int INDEX_BITS    = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [15:0] rsp_stream_index,
   output logic [31:0] rsp_start_offset,
   output logic [32:0] rsp_stream_length,
   output logic        rsp_big_endian,
   output logic        rsp_form_xwma,
   input  wire         csr_wr_en,
   input  wire  [1:0]  csr_index,
   input  wire  [32:0] csr_wr_data
);
   import rsc_pkg::*;

   localparam int SW = ((POSITION_BITS > LENGTH_BITS) ? POSITION_BITS : LENGTH_BITS) + 1;
   localparam int IW = (INDEX_BITS > 16) ? INDEX_BITS : 16;
   localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(WINDOW_BYTES - 1);

   logic [LENGTH_BITS-1:0]   min_len_ff;
   logic [LENGTH_BITS-1:0]   max_len_ff;
   logic [TOTAL_BITS-1:0]    total_ff;

   logic [POSITION_BITS-1:0] pos_ff,  pos_in;
   logic [FILL_BITS-1:0]     fill_ff, fill_in;
   logic [LENGTH_BITS-1:0]   skip_ff, skip_in;
   logic [INDEX_BITS-1:0]    cnt_ff,  cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [15:0]              out_index_ff;
   logic [31:0]              out_start_ff;
   logic [LENGTH_BITS-1:0]   out_length_ff;
   logic                     out_be_ff;
   logic                     out_xwma_ff;

   hdr_type                  hdr;
   logic                     req_fire;
   logic                     skipping;
   logic                     full;
   logic                     shift_en;
   logic                     hit;
   logic                     long_cont;
   logic [POSITION_BITS-1:0] start;
   logic [SW-1:0]            start_w;
   logic [SW-1:0]            total_w;
   logic [LENGTH_BITS-1:0]   length;
   logic [IW-1:0]            cnt_w;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign skipping  = (skip_ff != '0);
   assign full      = (fill_ff == FILL_FULL);
   assign shift_en  = req_fire && !skipping;

   rsc_window u_window (
      .clock     (clock),
      .shift_en  (shift_en),
      .data_byte (req_data_byte),
      .hdr       (hdr)
   );

   always_comb begin
      start     = pos_ff - POSITION_BITS'(WINDOW_BYTES - 1);
      start_w   = SW'(start);
      total_w   = SW'(total_ff);
      length    = LENGTH_BITS'(hdr.size) + LENGTH_BITS'(HEADER_BYTES);
      long_cont = (length >= LENGTH_BITS'(WINDOW_BYTES));
      hit = shift_en && full && hdr.tag_ok
            && (start_w + SW'(WINDOW_BYTES) <= total_w)
            && (length >= min_len_ff) && (length <= max_len_ff)
            && (start_w + SW'(length) <= total_w);
      cnt_w = IW'(cnt_ff);
   end

   always_comb begin
      pos_in  = pos_ff;
      fill_in = fill_ff;
      skip_in = skip_ff;
      cnt_in  = cnt_ff;
      if (req_fire) begin
         pos_in = pos_ff + 1'b1;
         priority if (skipping) begin
            skip_in = skip_ff - 1'b1;
         end else if (!full) begin
            fill_in = fill_ff + 1'b1;
         end else if (hit) begin
            cnt_in = cnt_ff + 1'b1;
            if (long_cont) begin
               fill_in = '0;
               skip_in = length - LENGTH_BITS'(WINDOW_BYTES);
            end else begin
               fill_in = FILL_BITS'(WINDOW_BYTES) - length[FILL_BITS-1:0];
            end
         end else begin
            fill_in = FILL_FULL;
         end
      end
      rsp_valid_in = hit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         fill_ff      <= '0;
         skip_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         skip_ff      <= skip_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= MIN_LENGTH_RESET;
         max_len_ff <= MAX_LENGTH_RESET;
         total_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MIN_LENGTH:   min_len_ff <= csr_wr_data;
            CSR_MAX_LENGTH:   max_len_ff <= csr_wr_data;
            CSR_TOTAL_LENGTH: total_ff   <= csr_wr_data[TOTAL_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (hit) begin
         out_index_ff  <= cnt_w[15:0];
         out_start_ff  <= start_w[31:0];
         out_length_ff <= length;
         out_be_ff     <= hdr.big_endian;
         out_xwma_ff   <= hdr.form_xwma;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_stream_index  = out_index_ff;
   assign rsp_start_offset  = out_start_ff;
   assign rsp_stream_length = out_length_ff;
   assign rsp_big_endian    = out_be_ff;
   assign rsp_form_xwma     = out_xwma_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("window fill out of range");

   a_skip_holds_window: assert property (@(posedge clock) disable iff (reset)
      (req_fire && skipping) |=> $stable(fill_ff))
      else $error("window moved while skipping container bytes");

   a_long_skip: assert property (@(posedge clock) disable iff (reset)
      (hit && long_cont) |=>
         (fill_ff == '0) && (skip_ff == $past(length) - LENGTH_BITS'(WINDOW_BYTES)))
      else $error("skip count wrong after accepted container");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      hit |=> (cnt_ff == $past(cnt_ff) + 1'b1) && rsp_valid_ff)
      else $error("index or result valid not updated on accept");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
module testbench;
   import rsc_pkg::*;

   localparam logic [32:0] LEN_ALL_ONES = '1;
   localparam logic [1:0]  CSR_SPARE    = 2'd3;
   localparam int          ITEM_TARGET  = 1650;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          HOLD_AFTER   = 6;
   localparam int          STALL_LIMIT  = 5000;
   localparam int          SETTLE_CYCLES = 4;
   localparam int          DRAIN_CYCLES = 10;
   localparam int          CALM_FROM    = 1000;
   localparam int          CALM_TO      = 2000;

   typedef struct packed {
      logic [15:0] idx;
      logic [31:0] offset;
      logic [32:0] len;
      logic        big;
      logic        xwma;
   } container_type;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready     = 1'b0;
   logic [15:0] rsp_stream_index;
   logic [31:0] rsp_start_offset;
   logic [32:0] rsp_stream_length;
   logic        rsp_big_endian;
   logic        rsp_form_xwma;
   logic        csr_wr_en     = 1'b0;
   logic [1:0]  csr_index     = CSR_MIN_LENGTH;
   logic [32:0] csr_wr_data   = '0;

   riff_stream_carver u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_stream_index  (rsp_stream_index),
      .rsp_start_offset  (rsp_start_offset),
      .rsp_stream_length (rsp_stream_length),
      .rsp_big_endian    (rsp_big_endian),
      .rsp_form_xwma     (rsp_form_xwma),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   // carver state mirror
   byte_type    carve_win [WINDOW_BYTES];
   int unsigned window_fill = 0;
   logic [31:0] scan_pos    = '0;
   logic [32:0] skip_left   = '0;
   logic [15:0] found_count = '0;
   logic [32:0] min_len_cfg = MIN_LENGTH_RESET;
   logic [32:0] max_len_cfg = MAX_LENGTH_RESET;
   logic [31:0] total_len_cfg = '0;

   container_type due_containers [$];
   byte_type    byte_feed [$];
   byte_type    buffer_bytes [$];
   int          item_count     = 0;
   int          mismatch_count = 0;
   int          idle_cycles    = 0;
   int          cycle_count    = 0;
   int          carved_seen    = 0;
   int          hold_left      = 0;
   bit          hold_done      = 1'b0;
   logic        calm;

   assign calm = cycle_count >= CALM_FROM && cycle_count < CALM_TO;

   initial begin
      for (int i = 0; i < WINDOW_BYTES; i++) carve_win[i] = 8'h00;
      forever #5 clock = ~clock;
   end

   task automatic carve_byte(input byte_type data);
      logic [31:0] here;
      logic [31:0] start;
      logic [31:0] tag_word;
      logic [31:0] form_word;
      logic [31:0] size;
      logic [63:0] len64;
      logic        is_rifx;
      logic        is_xwma;
      int unsigned drop;
      container_type hit;
      here = scan_pos;
      scan_pos = here + 32'd1;
      if (skip_left != '0) begin
         skip_left = skip_left - 33'd1;
         return;
      end
      if (window_fill >= WINDOW_BYTES) window_fill = WINDOW_BYTES - 1;
      carve_win[window_fill] = data;
      window_fill++;
      if (window_fill < WINDOW_BYTES) return;
      start = here - 32'(WINDOW_BYTES - 1);
      tag_word  = {carve_win[0], carve_win[1], carve_win[2], carve_win[3]};
      form_word = {carve_win[8], carve_win[9], carve_win[10], carve_win[11]};
      is_rifx = tag_word == TAG_RIFX;
      is_xwma = form_word == FORM_XWMA;
      drop = 1;
      if ((tag_word == TAG_RIFF || is_rifx) && (form_word == FORM_WAVE || is_xwma)) begin
         if (is_rifx) size = {carve_win[4], carve_win[5], carve_win[6], carve_win[7]};
         else size = {carve_win[7], carve_win[6], carve_win[5], carve_win[4]};
         len64 = 64'(size) + 64'(HEADER_BYTES);
         if (64'(start) + 64'(WINDOW_BYTES) <= 64'(total_len_cfg) &&
             len64 >= 64'(min_len_cfg) && len64 <= 64'(max_len_cfg) &&
             64'(start) + len64 <= 64'(total_len_cfg)) begin
            hit.idx    = found_count;
            hit.offset = start;
            hit.len    = len64[32:0];
            hit.big    = is_rifx;
            hit.xwma   = is_xwma;
            due_containers.push_back(hit);
            found_count = found_count + 16'd1;
            if (len64 >= 64'(WINDOW_BYTES)) begin
               window_fill = 0;
               skip_left = 33'(len64 - 64'(WINDOW_BYTES));
               return;
            end
            drop = int'(len64);
         end
      end
      // drop one byte, or a short container's length, and keep the tail of the window
      for (int i = 0; i < WINDOW_BYTES; i++)
         carve_win[i] = (i + drop < WINDOW_BYTES) ? carve_win[i + drop] : 8'h00;
      window_fill = WINDOW_BYTES - drop;
   endtask

   always @(posedge clock) begin
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MIN_LENGTH:   min_len_cfg = csr_wr_data;
            CSR_MAX_LENGTH:   max_len_cfg = csr_wr_data;
            CSR_TOTAL_LENGTH: total_len_cfg = csr_wr_data[31:0];
            default: ;
         endcase
      end
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) carve_byte(req_data_byte);
         if (!req_valid || req_ready) begin
            if (byte_feed.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
               req_valid     <= 1'b1;
               req_data_byte <= byte_feed.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void check_container();
      container_type want;
      if (due_containers.size() == 0) begin
         $display("%0t: unexpected transaction, expected none actual offset %0h",
                  $time, rsp_start_offset);
         mismatch_count++;
         return;
      end
      want = due_containers.pop_front();
      check_field("stream_index", 64'(want.idx), 64'(rsp_stream_index));
      check_field("start_offset", 64'(want.offset), 64'(rsp_start_offset));
      check_field("stream_length", 64'(want.len), 64'(rsp_stream_length));
      check_field("big_endian", 64'(want.big), 64'(rsp_big_endian));
      check_field("form_xwma", 64'(want.xwma), 64'(rsp_form_xwma));
   endfunction

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_container();
            carved_seen <= carved_seen + 1;
         end
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (!hold_done && carved_seen == HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || $urandom_range(99) >= 6;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic put_item(input byte_type b);
      buffer_bytes.push_back(b);
      item_count++;
   endtask

   task automatic put_header(input bit big, input bit xwma, input logic [31:0] size);
      logic [31:0] tag_word;
      logic [31:0] form_word;
      tag_word  = big ? TAG_RIFX : TAG_RIFF;
      form_word = xwma ? FORM_XWMA : FORM_WAVE;
      for (int i = 0; i < 4; i++) put_item(tag_word[31-8*i -: 8]);
      for (int i = 0; i < 4; i++) put_item(big ? size[31-8*i -: 8] : size[8*i +: 8]);
      for (int i = 0; i < 4; i++) put_item(form_word[31-8*i -: 8]);
   endtask

   task automatic put_container(input bit big, input bit xwma, input logic [31:0] size);
      put_header(big, xwma, size);
      if (size >= 32'd4 && size < 32'd4096)
         repeat (size - 32'd4) put_item(8'($urandom()));
   endtask

   task automatic put_random_group();
      int unsigned pick;
      int unsigned at;
      int unsigned k;
      logic [31:0] size;
      pick = $urandom_range(99);
      if (pick < 70) begin
         if ($urandom_range(9) == 0) size = $urandom_range(3);
         else if ($urandom_range(19) == 0) size = $urandom();
         else size = $urandom_range(4, 60);
         put_container(1'($urandom_range(1)), 1'($urandom_range(1)), size);
      end else if (pick < 82) begin
         at = buffer_bytes.size();
         put_header(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom_range(4, 40));
         k = $urandom_range(7);
         at = at + ((k < 4) ? k : k + 4);
         buffer_bytes[at] = buffer_bytes[at] ^ 8'(1 << $urandom_range(7));
      end else if (pick < 88) begin
         put_item(TAG_RIFF[31:24]);
         put_item(TAG_RIFF[23:16]);
         put_item(TAG_RIFF[15:8]);
      end else begin
         repeat ($urandom_range(1, 8)) put_item(8'($urandom()));
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (!(byte_feed.size() == 0 && !req_valid && due_containers.size() == 0));
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [32:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
   endtask

   task automatic write_regs(input logic [32:0] lo, input logic [32:0] hi,
                             input logic [32:0] tot);
      write_reg(CSR_MIN_LENGTH, lo);
      write_reg(CSR_MAX_LENGTH, hi);
      write_reg(CSR_TOTAL_LENGTH, tot);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_phase();
      @(negedge clock);
      while (buffer_bytes.size() != 0) byte_feed.push_back(buffer_bytes.pop_front());
   endtask

   initial begin
      logic [31:0] base;
      logic [31:0] tot;
      logic [32:0] lo;
      logic [32:0] hi;
      int unsigned near_end;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // default registers, empty buffer: nothing fits
      wait_idle();
      put_header(1'b0, 1'b0, 32'd1016);
      send_phase();

      // minimum container, short containers, tag near the end, bytes past the buffer
      wait_idle();
      base = scan_pos;
      put_item(8'h00);
      put_item(8'hFF);
      put_container(1'b0, 1'b0, 32'd4);
      put_container(1'b1, 1'b1, 32'd1);
      put_container(1'b0, 1'b1, 32'd0);
      near_end = buffer_bytes.size();
      put_header(1'b0, 1'b0, 32'd4);
      put_header(1'b1, 1'b1, 32'd0);
      tot = base + 32'(near_end) + 32'd6;
      write_regs('0, LEN_ALL_ONES, {1'b1, tot});
      send_phase();

      // largest size fields against the widest buffer; spare index ignored
      wait_idle();
      write_reg(CSR_SPARE, LEN_ALL_ONES);
      write_regs('0, LEN_ALL_ONES, {1'b0, 32'hFFFF_FFFF});
      put_header(1'b0, 1'b1, 32'hFFFF_FFFF);
      put_header(1'b1, 1'b0, 32'hFFFF_FFF7);
      send_phase();

      // empty length range
      wait_idle();
      write_regs(LEN_ALL_ONES, '0, {1'b0, 32'hFFFF_FFFF});
      put_container(1'b0, 1'b0, 32'd4);
      send_phase();

      while (item_count < ITEM_TARGET) begin
         wait_idle();
         base = scan_pos;
         repeat ($urandom_range(8, 16)) put_random_group();
         tot = base + 32'(buffer_bytes.size()) - 32'($urandom_range(24));
         case ($urandom_range(3))
            0: begin
               lo = '0;
               hi = LEN_ALL_ONES;
            end
            1: begin
               lo = 33'($urandom_range(8, 20));
               hi = 33'($urandom_range(30, 80));
               tot = 32'hFFFF_FFFF;
            end
            2: begin
               lo = 33'd12;
               hi = 33'($urandom_range(16, 100));
            end
            default: begin
               lo = 33'd8;
               hi = 33'd64;
               tot = 32'hFFFF_FFFF;
            end
         endcase
         write_regs(lo, hi, {1'b0, tot});
         send_phase();
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/rsc_pkg.sv
rtl/core/rsc_cell.sv
rtl/core/rsc_window.sv
rtl/core/riff_stream_carver.sv
tb/testbench.sv
